// ===== sv/tlbp_pkg.sv =====
// Shared definitions for the two-level local-history branch predictor.
// Holds sizing defaults, opcode and counter constants, the controller state type
// and the saturating counter step. No dependencies.
package tlbp_pkg;

  localparam int PC_BITS          = 12;
  localparam int DEF_HIST_BITS    = 6;
  localparam int DEF_HIST_ENTRIES = 512;
  localparam int DEF_PATTERN_SETS = 8;
  localparam int CTR_W            = 2;

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  localparam logic [CTR_W-1:0] CTR_RESET = 2'd1;
  localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;
  localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_HIST,
    S_CTR,
    S_RESP
  } state_t;

  // One step of a two-bit saturating counter toward the resolved outcome.
  function automatic logic [CTR_W-1:0] ctr_next(input logic [CTR_W-1:0] c,
                                                input logic tk);
    logic [CTR_W-1:0] r;
    r = c;
    if (tk) begin
      if (c != CTR_MAX) r = c + CTR_W'(1);
    end else begin
      if (c != CTR_MIN) r = c - CTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/tlbp_cdiv.sv =====
// Two-stage divider by a fixed constant: reciprocal multiply, then remainder.
// The reciprocal product and the delayed dividend are registered first, then the quotient and remainder outputs.
// Depends on tlbp_pkg for the default dividend width.
module tlbp_cdiv import tlbp_pkg::*; #(
  parameter int N_BITS  = PC_BITS,
  parameter int DIVISOR = DEF_PATTERN_SETS
) (
  input  logic              clk,
  input  logic [N_BITS-1:0] n_i,
  output logic [N_BITS-1:0] q_o,
  output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] r_o
);

  localparam int     R_W   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
  localparam int     L     = $clog2(DIVISOR);
  localparam int     K     = N_BITS + L;
  localparam int     P_W   = K + N_BITS + 1;
  // Rounded-up reciprocal; with K = N_BITS + ceil(log2 DIVISOR) the quotient is exact.
  localparam longint RECIP = ((longint'(1) << K) + longint'(DIVISOR) - 1) / DIVISOR;
  localparam logic [N_BITS-1:0] D_N = N_BITS'(DIVISOR);

  logic [P_W-1:0]    prod_r;
  logic [N_BITS-1:0] n_d_r;
  logic [N_BITS-1:0] q_w;
  logic [N_BITS-1:0] qd_w;
  logic [N_BITS-1:0] rem_w;

  always_ff @(posedge clk) begin
    prod_r <= P_W'(n_i) * P_W'(RECIP);
    n_d_r  <= n_i;
  end

  // The remainder is below 2**N_BITS, so wrapping arithmetic gives it exactly.
  always_comb begin
    q_w   = prod_r[K +: N_BITS];
    qd_w  = q_w * D_N;
    rem_w = n_d_r - qd_w;
  end

  always_ff @(posedge clk) begin
    q_o <= q_w;
    r_o <= R_W'(rem_w);
  end

endmodule

// ===== sv/two_level_local_branch_predictor.sv =====
// Top level of the two-level local-history branch predictor.
// Uses tlbp_pkg and two tlbp_cdiv instances for the set and history row.
//
// Input channel (in_valid/in_stall): a word carries in_opcode, in_pc and
// in_taken and is taken at an edge where in_valid is high and in_stall low.
// A predict word yields one output word on out_valid/out_predict_taken; an
// update word yields none and trains the counter and the history register.
// Items are handled one at a time: an accepted word passes through the two
// constant dividers that form the set and row (S_INDEX), then the history
// read (S_HIST), the counter read (S_CTR) and the step that responds or
// writes back (S_RESP). The next word is accepted only after S_RESP ends, and
// a prediction shows on out_valid from the output register set in S_RESP.
// The output register holds its word while out_stall is high, and the block
// keeps accepting input meanwhile; only a response that would overwrite a
// waiting word holds the controller until the receiver takes it.
// After reset a clearing pass writes every history to zero and every counter
// to weakly not taken, one entry per cycle, over
// max(HIST_ENTRIES, PATTERN_SETS * 2**HIST_BITS) addresses (512 by default);
// in_stall stays high during that pass.
module two_level_local_branch_predictor import tlbp_pkg::*; #(
  parameter int HIST_BITS    = DEF_HIST_BITS,
  parameter int HIST_ENTRIES = DEF_HIST_ENTRIES,
  parameter int PATTERN_SETS = DEF_PATTERN_SETS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [PC_BITS-1:0] in_pc,
  input  logic               in_taken,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_predict_taken
);

  localparam int SET_W     = (PATTERN_SETS > 1) ? $clog2(PATTERN_SETS) : 1;
  localparam int HADDR_W   = $clog2(HIST_ENTRIES);
  localparam int CTR_DEPTH = PATTERN_SETS << HIST_BITS;
  localparam int CADDR_W   = $clog2(CTR_DEPTH);
  localparam int CLR_DEPTH = (HIST_ENTRIES > CTR_DEPTH) ? HIST_ENTRIES : CTR_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam logic [1:0] IDX_LAST = 2'd3;

  state_t state_r, state_nxt;
  logic [1:0]       wait_r, wait_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_taken_r, out_taken_nxt;

  logic               op_r;
  logic [PC_BITS-1:0] pc_r;
  logic               taken_r;

  logic [PC_BITS-1:0] q1_w;
  logic [SET_W-1:0]   set_w;
  logic [HADDR_W-1:0] row_w;

  logic [HIST_BITS-1:0] hist_mem [HIST_ENTRIES];
  logic [CTR_W-1:0]     ctr_mem  [CTR_DEPTH];
  logic [HIST_BITS-1:0] hist_q_r;
  logic [CTR_W-1:0]     ctr_q_r;

  logic                 hist_re, hist_we;
  logic [HADDR_W-1:0]   hist_waddr;
  logic [HIST_BITS-1:0] hist_wdata;
  logic                 ctr_re, ctr_we;
  logic [CADDR_W-1:0]   ctr_raddr, ctr_waddr;
  logic [CTR_W-1:0]     ctr_wdata;
  logic                 accept;

  tlbp_cdiv #(.N_BITS(PC_BITS), .DIVISOR(PATTERN_SETS)) u_set_div (
    .clk (clk),
    .n_i (pc_r),
    .q_o (q1_w),
    .r_o (set_w)
  );

  tlbp_cdiv #(.N_BITS(PC_BITS), .DIVISOR(HIST_ENTRIES)) u_row_div (
    .clk (clk),
    .n_i (q1_w),
    .q_o (),
    .r_o (row_w)
  );

  assign in_stall          = (state_r != S_IDLE);
  assign accept            = in_valid && (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_taken_r;
  // With a single set the set field is zero and the truncation drops it.
  assign ctr_raddr         = CADDR_W'({set_w, hist_q_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      wait_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_taken_r <= out_taken_nxt;
    if (accept) begin
      op_r    <= in_opcode;
      pc_r    <= in_pc;
      taken_r <= in_taken;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_taken_nxt = out_taken_r;
    hist_re       = 1'b0;
    hist_we       = 1'b0;
    hist_waddr    = row_w;
    hist_wdata    = HIST_BITS'({hist_q_r, taken_r});
    ctr_re        = 1'b0;
    ctr_we        = 1'b0;
    ctr_waddr     = ctr_raddr;
    ctr_wdata     = ctr_next(ctr_q_r, taken_r);
    case (state_r)
      S_CLEAR: begin
        hist_waddr = clr_r[HADDR_W-1:0];
        hist_wdata = '0;
        hist_we    = ({1'b0, clr_r} < (CLR_W+1)'(HIST_ENTRIES));
        ctr_waddr  = clr_r[CADDR_W-1:0];
        ctr_wdata  = CTR_RESET;
        ctr_we     = ({1'b0, clr_r} < (CLR_W+1)'(CTR_DEPTH));
        clr_nxt    = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          wait_nxt  = '0;
          state_nxt = S_INDEX;
        end
      end
      S_INDEX: begin
        // The row is settled only after the value has passed the registers of both dividers in turn.
        wait_nxt = wait_r + 2'd1;
        if (wait_r == IDX_LAST) begin
          state_nxt = S_HIST;
        end
      end
      S_HIST: begin
        hist_re   = 1'b1;
        state_nxt = S_CTR;
      end
      S_CTR: begin
        ctr_re    = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (op_r == OP_UPDATE) begin
          hist_we   = 1'b1;
          ctr_we    = 1'b1;
          state_nxt = S_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_taken_nxt = ctr_q_r[CTR_W-1];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (hist_re) hist_q_r <= hist_mem[row_w];
  end

  always_ff @(posedge clk) begin
    if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
    if (ctr_re) ctr_q_r <= ctr_mem[ctr_raddr];
  end

endmodule
